// File: design/mdq_pkg.sv
// Shared types and constants for the matrix decomposition block.
// Depends on nothing; every other design file imports it.
`timescale 1ns / 1ps

package mdq_pkg;

  localparam int WORD_WIDTH = 32;
  localparam int UNIT_BITS  = 30;
  localparam int SQRT_STEPS = WORD_WIDTH;
  localparam int DIV_SHORT  = 31;
  localparam int DIV_LONG   = 48;

  typedef logic signed [WORD_WIDTH-1:0] word_t;
  typedef logic [WORD_WIDTH-1:0]        uword_t;

  // Result status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_W_ZERO = 2'd1;
  localparam logic [1:0] ST_ZERO   = 2'd2;

  // 1.0 in Q4.30, wide enough for trace arithmetic
  localparam logic signed [33:0] ONE_Q30 = 34'sh0_4000_0000;

  typedef enum logic [3:0] {
    OP_IDLE,
    OP_SQ,
    OP_ACC,
    OP_LEN_GO,
    OP_LEN_WAIT,
    OP_NORM_GO,
    OP_NORM_WAIT,
    OP_TRACE,
    OP_ARG,
    OP_ROOT_GO,
    OP_ROOT_WAIT,
    OP_Q_GO,
    OP_Q_WAIT,
    OP_EMIT
  } op_t;

  typedef struct packed {
    op_t        op;
    logic       take;
    logic [1:0] col;
    logic [1:0] row;
    logic [1:0] code;
  } cmd_t;

  typedef struct packed {
    logic col3;
    logic w_zero;
    logic sqrt_done;
    logic div_done;
    logic len_zero;
    logic arg_pos;
    logic out_busy;
  } stat_t;

endpackage

// File: design/mdq_if.sv
// Valid/ready channel interfaces for column items and result items.
// Depends on mdq_pkg.
`timescale 1ns / 1ps

interface mdq_col_if import mdq_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [1:0] column_index;
  word_t      row0_value;
  word_t      row1_value;
  word_t      row2_value;
  word_t      row3_value;

  modport source (output valid, column_index, row0_value, row1_value, row2_value,
                  row3_value, input ready);
  modport sink (input valid, column_index, row0_value, row1_value, row2_value,
                row3_value, output ready);
endinterface

interface mdq_res_if import mdq_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [1:0] status;
  word_t      move_x;
  word_t      move_y;
  word_t      move_z;
  uword_t     size_x;
  uword_t     size_y;
  uword_t     size_z;
  word_t      quat_w;
  word_t      quat_x;
  word_t      quat_y;
  word_t      quat_z;

  modport source (output valid, status, move_x, move_y, move_z, size_x, size_y, size_z,
                  quat_w, quat_x, quat_y, quat_z, input ready);
  modport sink (input valid, status, move_x, move_y, move_z, size_x, size_y, size_z,
                quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

// File: design/mdq_sqrt.sv
// Iterative integer square root, one result bit per cycle.
// Depends on mdq_pkg.
`timescale 1ns / 1ps

module mdq_sqrt import mdq_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] radicand,
  output logic        done,
  output uword_t      root
);

  logic [63:0] x_q;
  logic [33:0] rem_q;
  logic [5:0]  cnt_q;
  logic        busy_q;
  logic [35:0] t;
  logic [35:0] trial;
  logic        ge;

  // Bring down two radicand bits and try the next root bit
  assign t     = {rem_q, x_q[63:62]};
  assign trial = {2'b00, root, 2'b01};
  assign ge    = (t >= trial);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy_q <= 1'b0;
      done   <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        x_q    <= radicand;
        rem_q  <= '0;
        root   <= '0;
        cnt_q  <= 6'(SQRT_STEPS);
        busy_q <= 1'b1;
      end else if (busy_q) begin
        x_q   <= {x_q[61:0], 2'b00};
        rem_q <= ge ? 34'(t - trial) : 34'(t);
        root  <= {root[WORD_WIDTH-2:0], ge};
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == 6'd1) begin
          busy_q <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

endmodule

// File: design/mdq_div.sv
// Restoring divider on magnitudes, one quotient bit per cycle.
// Short mode gives 31 quotient bits, long mode 48. Depends on mdq_pkg.
`timescale 1ns / 1ps

module mdq_div import mdq_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        long_mode,
  input  logic [63:0] num,
  input  uword_t      den,
  output logic        done,
  output logic [47:0] quo
);

  uword_t      rem_q;
  uword_t      den_q;
  logic [63:0] sh_q;
  logic [5:0]  cnt_q;
  logic        busy_q;
  logic [32:0] t;
  logic        ge;

  // Shift in the next dividend bit and subtract when it fits
  assign t  = {rem_q, sh_q[63]};
  assign ge = (t >= {1'b0, den_q});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy_q <= 1'b0;
      done   <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        den_q  <= den;
        quo    <= '0;
        busy_q <= 1'b1;
        if (long_mode) begin
          rem_q <= WORD_WIDTH'(num >> DIV_LONG);
          sh_q  <= num << (64 - DIV_LONG);
          cnt_q <= 6'(DIV_LONG);
        end else begin
          rem_q <= WORD_WIDTH'(num >> DIV_SHORT);
          sh_q  <= num << (64 - DIV_SHORT);
          cnt_q <= 6'(DIV_SHORT);
        end
      end else if (busy_q) begin
        sh_q  <= {sh_q[62:0], 1'b0};
        rem_q <= ge ? WORD_WIDTH'(t - {1'b0, den_q}) : WORD_WIDTH'(t);
        quo   <= {quo[46:0], ge};
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == 6'd1) begin
          busy_q <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

endmodule

// File: design/mdq_datapath.sv
// Datapath: axis store, squaring multiplier, accumulator, normalized matrix,
// trace logic, shared square root and divider, and the result register.
// Depends on mdq_pkg, mdq_if, mdq_sqrt and mdq_div.
`timescale 1ns / 1ps

module mdq_datapath import mdq_pkg::*; (
  input  logic clk,
  input  logic rst,
  mdq_col_if.sink   column,
  mdq_res_if.source result,
  input  cmd_t  cmd,
  output stat_t stat
);

  word_t        axis_q [9];
  word_t        move_q [3];
  logic         w_zero_q;
  logic         accept;
  logic [3:0]   wbase;
  logic [3:0]   sidx;
  word_t        entry;
  uword_t       entry_mag;
  logic [63:0]  prod_q;
  logic [63:0]  acc_q;
  uword_t       len_q [3];
  word_t        n_q [9];
  logic signed [33:0] trace_q;
  logic signed [33:0] arg_q;
  logic signed [33:0] diag;
  logic [1:0]   idx_q;
  logic [1:0]   idx_pick;
  logic         big1;
  word_t        dmax;
  logic         trace_pos;
  uword_t       root_q;
  word_t        qv_q [4];
  logic         neg_q;
  logic [1:0]   qslot_q;
  word_t        pa;
  word_t        pb;
  logic         psub;
  logic [1:0]   pslot;
  logic signed [32:0] d;
  logic [32:0]  d_mag;
  logic         sqrt_start;
  logic [63:0]  sqrt_in;
  logic         sqrt_done;
  uword_t       sqrt_root;
  logic         div_start;
  logic         div_long;
  logic [63:0]  div_num;
  uword_t       div_den;
  logic         div_done;
  logic [47:0]  div_quo;
  word_t        q_sat;
  logic         out_valid_q;

  assign column.ready = cmd.take;
  assign accept       = column.valid & cmd.take;
  assign wbase        = 4'({column.column_index, 1'b0}) + 4'(column.column_index);
  assign sidx         = 4'({cmd.col, 1'b0}) + 4'(cmd.col) + 4'(cmd.row);
  assign entry        = axis_q[sidx];
  assign entry_mag    = entry[WORD_WIDTH-1] ? uword_t'(-entry) : uword_t'(entry);
  assign trace_pos    = (trace_q > 34'sd0);

  // Capture stored columns, translation and the w check
  always_ff @(posedge clk) begin
    if (accept) begin
      if (column.column_index != 2'd3) begin
        axis_q[wbase]        <= column.row0_value;
        axis_q[wbase + 4'd1] <= column.row1_value;
        axis_q[wbase + 4'd2] <= column.row2_value;
      end else begin
        move_q[0] <= column.row0_value;
        move_q[1] <= column.row1_value;
        move_q[2] <= column.row2_value;
        w_zero_q  <= (column.row3_value == '0);
      end
    end
  end

  // Square and accumulate one axis entry per step
  always_ff @(posedge clk) begin
    if (cmd.op == OP_SQ) prod_q <= entry_mag * entry_mag;
    if (cmd.op == OP_ACC) acc_q <= ((cmd.row == 2'd0) ? 64'd0 : acc_q) + prod_q;
  end

  // Largest diagonal index
  assign big1     = (n_q[4] > n_q[0]);
  assign dmax     = big1 ? n_q[4] : n_q[0];
  assign idx_pick = (n_q[8] > dmax) ? 2'd2 : (big1 ? 2'd1 : 2'd0);

  // Diagonal-path root argument for the chosen index
  always_comb begin
    case (idx_q)
      2'd1:    diag = 34'(n_q[4]) - 34'(n_q[8]) - 34'(n_q[0]) + ONE_Q30;
      2'd2:    diag = 34'(n_q[8]) - 34'(n_q[0]) - 34'(n_q[4]) + ONE_Q30;
      default: diag = 34'(n_q[0]) - 34'(n_q[4]) - 34'(n_q[8]) + ONE_Q30;
    endcase
  end

  // Pick the entry pair and target slot of each off-root component
  always_comb begin
    pa = n_q[1]; pb = n_q[3]; psub = 1'b1; pslot = 2'd3;
    if (trace_pos) begin
      case (cmd.row)
        2'd0:    begin pa = n_q[5]; pb = n_q[7]; psub = 1'b1; pslot = 2'd1; end
        2'd1:    begin pa = n_q[6]; pb = n_q[2]; psub = 1'b1; pslot = 2'd2; end
        default: begin pa = n_q[1]; pb = n_q[3]; psub = 1'b1; pslot = 2'd3; end
      endcase
    end else begin
      case (idx_q)
        2'd1: begin
          case (cmd.row)
            2'd0:    begin pa = n_q[5]; pb = n_q[7]; psub = 1'b0; pslot = 2'd3; end
            2'd1:    begin pa = n_q[3]; pb = n_q[1]; psub = 1'b0; pslot = 2'd1; end
            default: begin pa = n_q[6]; pb = n_q[2]; psub = 1'b1; pslot = 2'd0; end
          endcase
        end
        2'd2: begin
          case (cmd.row)
            2'd0:    begin pa = n_q[6]; pb = n_q[2]; psub = 1'b0; pslot = 2'd1; end
            2'd1:    begin pa = n_q[7]; pb = n_q[5]; psub = 1'b0; pslot = 2'd2; end
            default: begin pa = n_q[1]; pb = n_q[3]; psub = 1'b1; pslot = 2'd0; end
          endcase
        end
        default: begin
          case (cmd.row)
            2'd0:    begin pa = n_q[1]; pb = n_q[3]; psub = 1'b0; pslot = 2'd2; end
            2'd1:    begin pa = n_q[2]; pb = n_q[6]; psub = 1'b0; pslot = 2'd3; end
            default: begin pa = n_q[5]; pb = n_q[7]; psub = 1'b1; pslot = 2'd0; end
          endcase
        end
      endcase
    end
  end

  assign d     = psub ? (33'(pa) - 33'(pb)) : (33'(pa) + 33'(pb));
  assign d_mag = d[32] ? 33'(-d) : 33'(d);

  // Shared unit operands
  assign sqrt_start = (cmd.op == OP_LEN_GO) || ((cmd.op == OP_ROOT_GO) && (arg_q > 34'sd0));
  assign sqrt_in    = (cmd.op == OP_LEN_GO) ? acc_q : {arg_q, 30'b0};
  assign div_start  = (cmd.op == OP_NORM_GO) || (cmd.op == OP_Q_GO);
  assign div_long   = (cmd.op == OP_Q_GO);
  assign div_num    = (cmd.op == OP_Q_GO) ? {2'b00, d_mag, 29'b0}
                                          : {2'b00, entry_mag, 30'b0};
  assign div_den    = (cmd.op == OP_Q_GO) ? root_q : len_q[cmd.col];

  mdq_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sqrt_start),
    .radicand (sqrt_in),
    .done     (sqrt_done),
    .root     (sqrt_root)
  );

  mdq_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .long_mode (div_long),
    .num       (div_num),
    .den       (div_den),
    .done      (div_done),
    .quo       (div_quo)
  );

  // Saturate a signed quotient to the word range
  always_comb begin
    if (neg_q) begin
      q_sat = (div_quo > 48'h0000_8000_0000) ? word_t'(32'h8000_0000)
                                             : word_t'(-div_quo[31:0]);
    end else begin
      q_sat = (div_quo > 48'h0000_7FFF_FFFF) ? word_t'(32'h7FFF_FFFF)
                                             : word_t'(div_quo[31:0]);
    end
  end

  // Lengths, normalized axes, trace, root and quaternion components
  always_ff @(posedge clk) begin
    if ((cmd.op == OP_LEN_WAIT) && sqrt_done) len_q[cmd.col] <= sqrt_root;
    if (cmd.op == OP_NORM_GO) neg_q <= entry[WORD_WIDTH-1];
    if ((cmd.op == OP_NORM_WAIT) && div_done) begin
      n_q[sidx] <= neg_q ? word_t'(-div_quo[31:0]) : word_t'(div_quo[31:0]);
    end
    if (cmd.op == OP_TRACE) begin
      trace_q <= 34'(n_q[0]) + 34'(n_q[4]) + 34'(n_q[8]);
      idx_q   <= idx_pick;
    end
    if (cmd.op == OP_ARG) arg_q <= trace_pos ? (trace_q + ONE_Q30) : diag;
    if ((cmd.op == OP_ROOT_WAIT) && sqrt_done) begin
      root_q <= sqrt_root;
      qv_q[trace_pos ? 2'd0 : (idx_q + 2'd1)] <= word_t'(sqrt_root >> 1);
    end
    if (cmd.op == OP_Q_GO) begin
      neg_q   <= d[32];
      qslot_q <= pslot;
    end
    if ((cmd.op == OP_Q_WAIT) && div_done) qv_q[qslot_q] <= q_sat;
  end

  // Result register: load on emit, drop on transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && result.ready) out_valid_q <= 1'b0;
      if ((cmd.op == OP_EMIT) && !out_valid_q) out_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if ((cmd.op == OP_EMIT) && !out_valid_q) begin
      result.status <= cmd.code;
      result.move_x <= (cmd.code == ST_W_ZERO) ? '0 : move_q[0];
      result.move_y <= (cmd.code == ST_W_ZERO) ? '0 : move_q[1];
      result.move_z <= (cmd.code == ST_W_ZERO) ? '0 : move_q[2];
      result.size_x <= (cmd.code == ST_W_ZERO) ? '0 : len_q[0];
      result.size_y <= (cmd.code == ST_W_ZERO) ? '0 : len_q[1];
      result.size_z <= (cmd.code == ST_W_ZERO) ? '0 : len_q[2];
      result.quat_w <= (cmd.code == ST_OK) ? qv_q[0] : '0;
      result.quat_x <= (cmd.code == ST_OK) ? qv_q[1] : '0;
      result.quat_y <= (cmd.code == ST_OK) ? qv_q[2] : '0;
      result.quat_z <= (cmd.code == ST_OK) ? qv_q[3] : '0;
    end
  end

  assign result.valid = out_valid_q;

  assign stat.col3      = accept && (column.column_index == 2'd3);
  assign stat.w_zero    = w_zero_q;
  assign stat.sqrt_done = sqrt_done;
  assign stat.div_done  = div_done;
  assign stat.len_zero  = (sqrt_root == '0);
  assign stat.arg_pos   = (arg_q > 34'sd0);
  assign stat.out_busy  = out_valid_q;

endmodule

// File: design/mdq_ctrl.sv
// Sequencer that steps the datapath through lengths, normalization,
// root and quaternion components. Depends on mdq_pkg.
`timescale 1ns / 1ps

module mdq_ctrl import mdq_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  stat_t stat,
  output cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_SQ, S_ACC, S_LEN_GO, S_LEN_WAIT, S_NORM_GO, S_NORM_WAIT,
    S_TRACE, S_ARG, S_ROOT_GO, S_ROOT_WAIT, S_Q_GO, S_Q_WAIT, S_EMIT
  } state_t;

  state_t     state;
  logic [1:0] col;
  logic [1:0] row;
  logic [1:0] code;
  logic       zero_axis;
  logic       zero_now;

  assign zero_now = zero_axis | ((state == S_LEN_WAIT) & stat.len_zero);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      col       <= '0;
      row       <= '0;
      code      <= ST_OK;
      zero_axis <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (stat.col3) state <= S_CHECK;
        end
        S_CHECK: begin
          col       <= '0;
          row       <= '0;
          zero_axis <= 1'b0;
          if (stat.w_zero) begin
            code  <= ST_W_ZERO;
            state <= S_EMIT;
          end else begin
            state <= S_SQ;
          end
        end
        S_SQ: state <= S_ACC;
        S_ACC: begin
          if (row == 2'd2) begin
            row   <= '0;
            state <= S_LEN_GO;
          end else begin
            row   <= row + 2'd1;
            state <= S_SQ;
          end
        end
        S_LEN_GO: state <= S_LEN_WAIT;
        S_LEN_WAIT: begin
          if (stat.sqrt_done) begin
            row <= '0;
            if (!stat.len_zero) begin
              state <= S_NORM_GO;
            end else begin
              zero_axis <= 1'b1;
              if (col == 2'd2) begin
                code  <= ST_ZERO;
                state <= S_EMIT;
              end else begin
                col   <= col + 2'd1;
                state <= S_SQ;
              end
            end
          end
        end
        S_NORM_GO: state <= S_NORM_WAIT;
        S_NORM_WAIT: begin
          if (stat.div_done) begin
            if (row != 2'd2) begin
              row   <= row + 2'd1;
              state <= S_NORM_GO;
            end else begin
              row <= '0;
              if (col != 2'd2) begin
                col   <= col + 2'd1;
                state <= S_SQ;
              end else if (zero_now) begin
                code  <= ST_ZERO;
                state <= S_EMIT;
              end else begin
                state <= S_TRACE;
              end
            end
          end
        end
        S_TRACE: state <= S_ARG;
        S_ARG:   state <= S_ROOT_GO;
        S_ROOT_GO: begin
          if (stat.arg_pos) begin
            state <= S_ROOT_WAIT;
          end else begin
            code  <= ST_ZERO;
            state <= S_EMIT;
          end
        end
        S_ROOT_WAIT: begin
          if (stat.sqrt_done) begin
            row   <= '0;
            state <= S_Q_GO;
          end
        end
        S_Q_GO: state <= S_Q_WAIT;
        S_Q_WAIT: begin
          if (stat.div_done) begin
            if (row == 2'd2) begin
              code  <= ST_OK;
              state <= S_EMIT;
            end else begin
              row   <= row + 2'd1;
              state <= S_Q_GO;
            end
          end
        end
        S_EMIT: begin
          if (!stat.out_busy) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Map each state to its datapath operation
  always_comb begin
    case (state)
      S_SQ:        cmd.op = OP_SQ;
      S_ACC:       cmd.op = OP_ACC;
      S_LEN_GO:    cmd.op = OP_LEN_GO;
      S_LEN_WAIT:  cmd.op = OP_LEN_WAIT;
      S_NORM_GO:   cmd.op = OP_NORM_GO;
      S_NORM_WAIT: cmd.op = OP_NORM_WAIT;
      S_TRACE:     cmd.op = OP_TRACE;
      S_ARG:       cmd.op = OP_ARG;
      S_ROOT_GO:   cmd.op = OP_ROOT_GO;
      S_ROOT_WAIT: cmd.op = OP_ROOT_WAIT;
      S_Q_GO:      cmd.op = OP_Q_GO;
      S_Q_WAIT:    cmd.op = OP_Q_WAIT;
      S_EMIT:      cmd.op = OP_EMIT;
      default:     cmd.op = OP_IDLE;
    endcase
    cmd.take = (state == S_IDLE);
    cmd.col  = col;
    cmd.row  = row;
    cmd.code = code;
  end

endmodule

// File: design/matrix_decompose_quaternion.sv
// Affine transform decomposition: translation, axis scale, rotation quaternion.
// Column items arrive on "column", results leave on "result" (valid/ready).
// Items for columns 0..2 are stored and give no result.
// A column 3 item starts the decomposition, which ends with one valid result.
// The time is set by the shared square root (used four times) and the shared
// divider (short mode for each of nine normalized entries, long mode for each
// of three quaternion components).
// A new item is taken only while the sequencer is idle; column stores may be
// taken while a result still waits in the output register.
// When the receiver stalls, the result is held; a following column 3 item is
// computed and then waits until the previous result has been transferred.
// A w of zero gives status 1.
// Reset is synchronous on rst and clears the sequencer and output valid; the
// stored axes are undefined until written.
// Depends on mdq_pkg, mdq_if, mdq_ctrl and mdq_datapath.
`timescale 1ns / 1ps

module matrix_decompose_quaternion import mdq_pkg::*; (
  input logic clk,
  input logic rst,
  mdq_col_if.sink   column,
  mdq_res_if.source result
);

  cmd_t  cmd;
  stat_t stat;

  mdq_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .cmd  (cmd)
  );

  mdq_datapath u_datapath (
    .clk    (clk),
    .rst    (rst),
    .column (column),
    .result (result),
    .cmd    (cmd),
    .stat   (stat)
  );

  // An emit into a free output register shows up as valid next cycle
  a_emit: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_EMIT) && !stat.out_busy |=> result.valid)
    else $error("emit did not load the result register");

  // Only defined status codes leave the block
  a_code: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (result.status == ST_OK) || (result.status == ST_W_ZERO) ||
                     (result.status == ST_ZERO))
    else $error("undefined status code");

  // A zero w clears the other fields; the check covers quat_w, size_x and move_x
  a_wzero: assert property (@(posedge clk) disable iff (rst)
    result.valid && (result.status == ST_W_ZERO) |->
      (result.quat_w == '0) && (result.size_x == '0) && (result.move_x == '0))
    else $error("fields not cleared on zero w");

endmodule

// File: tb/mdq_tb_if.sv
// Testbench-side note: the channel interfaces come from the design (mdq_if.sv).
// This file holds the column item and result types used by the testbench top.
// Depends on mdq_pkg.
`timescale 1ns / 1ps

package mdq_tb_pkg;
  import mdq_pkg::*;

  typedef struct {
    logic [1:0] col;
    word_t      r0;
    word_t      r1;
    word_t      r2;
    word_t      r3;
  } column_item_t;

  typedef struct {
    logic [1:0] status;
    word_t      mx, my, mz;
    uword_t     sx, sy, sz;
    word_t      qw, qx, qy, qz;
  } decomp_t;
endpackage

// File: tb/matrix_decompose_quaternion_tb.sv
// Testbench for matrix_decompose_quaternion: drives column transfers, predicts
// translation, scale and quaternion in fixed point, and checks every result.
// Depends on mdq_pkg, mdq_tb_pkg and the design's channel interfaces.
`timescale 1ns / 1ps

module matrix_decompose_quaternion_tb;
  import mdq_pkg::*;
  import mdq_tb_pkg::*;

  localparam int UNIT = 30;
  localparam int LATENCY = 700;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   errors = 0;
  logic stall_mode = 1'b0;

  mdq_col_if col_ch ();
  mdq_res_if res_ch ();

  matrix_decompose_quaternion dut (.clk(clk), .rst(rst), .column(col_ch.sink),
                                   .result(res_ch.source));

  always #2 clk = ~clk;

  // Predictor copy of the stored axes
  longint axes [9];
  bit     written [9];
  decomp_t expected_q [$];

  function automatic longint unsigned root64(longint unsigned x);
    longint unsigned res, bits;
    res = 0;
    bits = 64'd1 << 62;
    while (bits > x) bits >>= 2;
    while (bits != 0) begin
      if (x >= res + bits) begin
        x -= res + bits;
        res = (res >> 1) + bits;
      end else begin
        res >>= 1;
      end
      bits >>= 2;
    end
    return res;
  endfunction

  function automatic longint clamp_word(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint half_div(longint d, longint rt);
    return clamp_word((d * (64'sd1 <<< (UNIT - 1))) / rt);
  endfunction

  // Store a column or work out the decomposition of the held matrix
  function automatic void predict_column(column_item_t it);
    decomp_t e;
    longint nm [3][3];
    longint tr, arg, rt, qw;
    longint qv [3];
    longint unsigned s, len, m;
    bit zero_axis;
    int i, j, k;
    if (it.col != 2'd3) begin
      axes[it.col*3]   = longint'(it.r0);
      axes[it.col*3+1] = longint'(it.r1);
      axes[it.col*3+2] = longint'(it.r2);
      for (int r = 0; r < 3; r++) written[it.col*3+r] = 1'b1;
      return;
    end
    e = '{default: '0};
    zero_axis = 1'b0;
    if (it.r3 == 0) begin
      e.status = ST_W_ZERO;
      expected_q.push_back(e);
      return;
    end
    e.mx = it.r0;
    e.my = it.r1;
    e.mz = it.r2;
    for (int c = 0; c < 3; c++) begin
      s = 0;
      for (int r = 0; r < 3; r++) begin
        m = axes[c*3+r] < 0 ? -axes[c*3+r] : axes[c*3+r];
        s += m * m;
      end
      len = root64(s);
      if (c == 0) e.sx = len > 64'hFFFF_FFFF ? '1 : len[31:0];
      if (c == 1) e.sy = len > 64'hFFFF_FFFF ? '1 : len[31:0];
      if (c == 2) e.sz = len > 64'hFFFF_FFFF ? '1 : len[31:0];
      if (len == 0) zero_axis = 1'b1;
      else
        for (int r = 0; r < 3; r++)
          nm[c][r] = (axes[c*3+r] * (64'sd1 <<< UNIT)) / longint'(len);
    end
    if (zero_axis) begin
      e.status = ST_ZERO;
      expected_q.push_back(e);
      return;
    end
    tr = nm[0][0] + nm[1][1] + nm[2][2];
    if (tr > 0) begin
      rt = longint'(root64(longint'(unsigned'(tr + (64'sd1 <<< UNIT))) << UNIT));
      qw = rt / 2;
      qv[0] = half_div(nm[1][2] - nm[2][1], rt);
      qv[1] = half_div(nm[2][0] - nm[0][2], rt);
      qv[2] = half_div(nm[0][1] - nm[1][0], rt);
    end else begin
      i = 0;
      if (nm[1][1] > nm[0][0]) i = 1;
      if (nm[2][2] > nm[i][i]) i = 2;
      j = (i + 1) % 3;
      k = (j + 1) % 3;
      arg = nm[i][i] - nm[j][j] - nm[k][k] + (64'sd1 <<< UNIT);
      if (arg <= 0) begin
        e.status = ST_ZERO;
        expected_q.push_back(e);
        return;
      end
      rt = longint'(root64(longint'(unsigned'(arg)) << UNIT));
      qv[i] = rt / 2;
      qv[j] = half_div(nm[i][j] + nm[j][i], rt);
      qv[k] = half_div(nm[i][k] + nm[k][i], rt);
      qw = half_div(nm[j][k] - nm[k][j], rt);
    end
    e.status = ST_OK;
    e.qw = word_t'(clamp_word(qw));
    e.qx = word_t'(clamp_word(qv[0]));
    e.qy = word_t'(clamp_word(qv[1]));
    e.qz = word_t'(clamp_word(qv[2]));
    expected_q.push_back(e);
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // Send one column; random gaps come from the burst counter
  int burst_left = 0;
  task automatic send_column(column_item_t it);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 3) != 0) begin
        col_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
    burst_left--;
    col_ch.valid        <= 1'b1;
    col_ch.column_index <= it.col;
    col_ch.row0_value   <= it.r0;
    col_ch.row1_value   <= it.r1;
    col_ch.row2_value   <= it.r2;
    col_ch.row3_value   <= it.r3;
    @(posedge clk);
    while (!col_ch.ready) @(posedge clk);
    predict_column(it);
  endtask

  function automatic word_t rand_word();
    return word_t'($urandom);
  endfunction

  // Small magnitudes keep lengths in range; occasional full-range entries
  function automatic word_t rand_entry();
    case ($urandom_range(0, 7))
      0: return rand_word();
      1: return word_t'(0);
      default: return word_t'($signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000);
    endcase
  endfunction

  task automatic send_matrix(word_t a [9], word_t t0, word_t t1, word_t t2, word_t w);
    column_item_t it;
    for (int c = 0; c < 3; c++) begin
      it = '{col: 2'(c), r0: a[c*3], r1: a[c*3+1], r2: a[c*3+2], r3: rand_word()};
      send_column(it);
    end
    it = '{col: 2'd3, r0: t0, r1: t1, r2: t2, r3: w};
    send_column(it);
  endtask

  task automatic test_directed();
    word_t a [9];
    column_item_t it;
    // identity, w zero, zero axis
    a = '{32'sh10000, 0, 0, 0, 32'sh10000, 0, 0, 0, 32'sh10000};
    send_matrix(a, 32'sh7FFFFFFF, 32'sh80000000, 32'sh0, 32'sh10000);
    it = '{col: 2'd3, r0: 32'sh1234, r1: -5, r2: 7, r3: 0};
    send_column(it);
    a = '{0, 0, 0, 0, 32'sh10000, 0, 0, 0, 32'sh10000};
    send_matrix(a, -1, 1, 2, 32'sh80000000);
    // rotations of 180 degrees take each diagonal branch
    a = '{32'sh10000, 0, 0, 0, -32'sh10000, 0, 0, 0, -32'sh10000};
    send_matrix(a, 0, 0, 0, 32'sh7FFFFFFF);
    a = '{-32'sh10000, 0, 0, 0, 32'sh10000, 0, 0, 0, -32'sh10000};
    send_matrix(a, 0, 0, 0, 1);
    a = '{-32'sh10000, 0, 0, 0, -32'sh10000, 0, 0, 0, 32'sh10000};
    send_matrix(a, 0, 0, 0, -1);
    // full reflection is not detected and takes the diagonal path
    a = '{-32'sh10000, 0, 0, 0, -32'sh10000, 0, 0, 0, -32'sh10000};
    send_matrix(a, 0, 0, 0, 1);
    // extreme entries give scales near the top of the unsigned word range
    a = '{32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
          32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF, 32'sh1};
    send_matrix(a, 0, 0, 0, 5);
  endtask

  task automatic test_random_matrices(int n);
    word_t a [9];
    column_item_t it;
    for (int m = 0; m < n; m++) begin
      if ($urandom_range(0, 9) == 0) begin
        // overwrite one stored column out of order
        it = '{col: 2'($urandom_range(0, 2)), r0: rand_entry(), r1: rand_entry(),
               r2: rand_entry(), r3: rand_word()};
        send_column(it);
      end
      if ($urandom_range(0, 4) == 0) begin
        // repeat column 3 on held axes
        it = '{col: 2'd3, r0: rand_word(), r1: rand_word(), r2: rand_word(),
               r3: ($urandom_range(0, 5) == 0) ? word_t'(0) : rand_word()};
        send_column(it);
      end else begin
        foreach (a[x]) a[x] = rand_entry();
        send_matrix(a, rand_word(), rand_word(), rand_word(),
                    ($urandom_range(0, 15) == 0) ? word_t'(0) : rand_word());
      end
    end
  endtask

  task automatic test_stalled_receiver(int n);
    stall_mode = 1'b1;
    test_random_matrices(n);
    stall_mode = 1'b0;
  endtask

  // Receiver stalls on its own pattern
  int stall_phase = 0;
  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else begin
      stall_phase <= stall_phase + 1;
      if (stall_mode) res_ch.ready <= ($urandom_range(0, 3) == 0);
      else res_ch.ready <= (stall_phase % 64 < 40) ? 1'b1 : ($urandom_range(0, 1) == 1);
    end
  end

  // Check each result transfer against the oldest prediction
  always @(posedge clk) begin
    decomp_t e;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected result", res_ch.status, 0);
      end else begin
        e = expected_q.pop_front();
        if (res_ch.status !== e.status) report_mismatch("status", res_ch.status, e.status);
        if (res_ch.move_x !== e.mx) report_mismatch("move_x", res_ch.move_x, e.mx);
        if (res_ch.move_y !== e.my) report_mismatch("move_y", res_ch.move_y, e.my);
        if (res_ch.move_z !== e.mz) report_mismatch("move_z", res_ch.move_z, e.mz);
        if (res_ch.size_x !== e.sx) report_mismatch("size_x", res_ch.size_x, e.sx);
        if (res_ch.size_y !== e.sy) report_mismatch("size_y", res_ch.size_y, e.sy);
        if (res_ch.size_z !== e.sz) report_mismatch("size_z", res_ch.size_z, e.sz);
        if (res_ch.quat_w !== e.qw) report_mismatch("quat_w", res_ch.quat_w, e.qw);
        if (res_ch.quat_x !== e.qx) report_mismatch("quat_x", res_ch.quat_x, e.qx);
        if (res_ch.quat_y !== e.qy) report_mismatch("quat_y", res_ch.quat_y, e.qy);
        if (res_ch.quat_z !== e.qz) report_mismatch("quat_z", res_ch.quat_z, e.qz);
      end
    end
  end

  initial begin
    col_ch.valid        = 1'b0;
    col_ch.column_index = '0;
    col_ch.row0_value   = '0;
    col_ch.row1_value   = '0;
    col_ch.row2_value   = '0;
    col_ch.row3_value   = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random_matrices(240);
    test_stalled_receiver(50);
    col_ch.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
    if (errors == 0) $display("PASS matrix_decompose_quaternion");
    else $display("FAIL matrix_decompose_quaternion");
    $finish;
  end

  // Timeout far beyond the time needed for about 300 results
  initial begin
    #8ms;
    $display("FAIL matrix_decompose_quaternion");
    $finish;
  end
endmodule

// File: filelist.f
design/mdq_pkg.sv
design/mdq_if.sv
design/mdq_sqrt.sv
design/mdq_div.sv
design/mdq_datapath.sv
design/mdq_ctrl.sv
design/matrix_decompose_quaternion.sv
tb/mdq_tb_if.sv
tb/matrix_decompose_quaternion_tb.sv
